@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define CHK_PROP(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked property that must never hold.
`define CHK_NEVER(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) else $error(msg);

`endif

@@ rtl/wola_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wola_pkg
// Shared constants, types and the Hann weight table of the overlap-add block.
// ----------------------------------------------------------------------------
package wola_pkg;

  localparam int SEG_LEN   = 1024;
  localparam int POS_W     = 16;
  localparam int ACC_W     = 40;
  localparam int WS_W      = 24;
  localparam int SMP_W     = 16;
  localparam int W_W       = 16;
  localparam int QB        = 18;
  localparam int REM_W     = 42;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_NCH   = 1'b1;

  typedef logic [W_W-1:0] hann_tab_t [SEG_LEN];

  typedef struct packed {
    logic rd;
    logic wr_add;
    logic wr_clr;
    logic div;
  } lane_ctl_t;

  function automatic logic [W_W-1:0] hann_entry(int unsigned i);
    logic [63:0] k;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s2;
    logic [63:0] w;
    logic signed [63:0] sum;
    int t;
    k = 64'(2 * i + 1);
    if (k > 64'(SEG_LEN)) k = 64'(2 * SEG_LEN) - k;
    x = (PI_Q30 * k) / 64'(2 * SEG_LEN);
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (t = 1; t <= 7; t++) begin
      term = ((term * x2) >> 30) / 64'((2 * t) * (2 * t + 1));
      if ((t % 2) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    s2 = unsigned'(sum) * unsigned'(sum);
    w = (s2 + (64'd1 << 43)) >> 44;
    if (w < 64'd1) w = 64'd1;
    if (w > 64'd65535) w = 64'd65535;
    return w[W_W-1:0];
  endfunction

  function automatic hann_tab_t hann_table();
    hann_tab_t tab;
    for (int i = 0; i < SEG_LEN; i++) tab[i] = hann_entry(i);
    return tab;
  endfunction

  localparam hann_tab_t HANN_ROM = hann_table();

endpackage

@@ rtl/windowed_overlap_add_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_overlap_add_normalizer
// Hann-weighted overlap-add with per-position window sums and normalized read.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. command selects add
//   (weight sample_ch0/1 by the Hann entry at segment_offset and accumulate
//   at segment_start+segment_offset), read (normalize one position) or clear.
//   Only read gives a result: out_ch0, out_ch1 and covered are valid in the
//   one cycle that done is high. The receiver cannot stall.
//   Add and clear step through ROM fetch, memory read and memory write.
//   A covered read goes on to the 18-step bit-serial divider in each channel
//   lane; an uncovered or out-of-range read ends after the memory read.
//   Both lanes divide side by side; the top passes each lane's quotient to its own output.
//   Configuration writes (wr_en, wr_index, wr_data) take effect at once; the user
//   must make them only while the block is idle; the block does not enforce it.
//   After reset, a clearing pass zeroes the accumulator and window-sum
//   memories one position a cycle; busy stays high throughout.
// ----------------------------------------------------------------------------
module windowed_overlap_add_normalizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command,
  input  logic [wola_pkg::POS_W-1:0]         segment_start,
  input  logic [9:0]                         segment_offset,
  input  logic signed [wola_pkg::SMP_W-1:0]  sample_ch0,
  input  logic signed [wola_pkg::SMP_W-1:0]  sample_ch1,
  output logic signed [wola_pkg::SMP_W-1:0]  out_ch0,
  output logic signed [wola_pkg::SMP_W-1:0]  out_ch1,
  output logic                               covered,
  output logic                               done,
  input  logic                               wr_en,
  input  logic                               wr_index,
  input  logic [16:0]                        wr_data
);
  import wola_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EXE, S_DIV} state_t;

  state_t                  state;
  logic [POS_W-1:0]        clr_addr;
  logic [16:0]             total_samples;
  logic [1:0]              num_channels;
  logic [1:0]              cmd_q;
  logic                    valid_q;
  logic [POS_W-1:0]        addr_q;
  logic [W_W-1:0]          w_q;
  logic signed [SMP_W-1:0] s0_q;
  logic signed [SMP_W-1:0] s1_q;
  logic [WS_W-1:0]         ws_mem [1 << POS_W];
  logic [WS_W-1:0]         ws_rd;
  logic [WS_W:0]           ws_sum;
  logic [16:0]             pos;
  logic                    ch1_on;
  logic                    accept;
  logic [POS_W-1:0]        maddr;
  lane_ctl_t               ctl0;
  lane_ctl_t               ctl1;
  logic signed [SMP_W-1:0] res0;
  logic signed [SMP_W-1:0] res1;
  logic                    rdone0;
  logic                    rdone1;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign pos    = {1'b0, segment_start} + 17'(segment_offset);
  assign ch1_on = num_channels >= 2'd2;
  assign maddr  = (state == S_CLR) ? clr_addr : addr_q;
  assign ws_sum = {1'b0, ws_rd} + (WS_W+1)'(w_q);

  always_comb begin
    ctl0.rd     = state == S_RD;
    ctl0.wr_clr = state == S_CLR || (state == S_EXE && valid_q && cmd_q == CMD_CLEAR);
    ctl0.wr_add = state == S_EXE && valid_q && cmd_q == CMD_ADD;
    ctl0.div    = state == S_EXE && valid_q && cmd_q == CMD_READ && ws_rd != '0;
    ctl1        = ctl0;
    ctl1.wr_add = ctl0.wr_add && ch1_on;
  end

  wola_lane u_lane0 (
    .clk(clk), .rst(rst), .ctl(ctl0), .addr(maddr), .weight(w_q), .sample(s0_q),
    .den(ws_rd), .res(res0), .res_done(rdone0)
  );

  wola_lane u_lane1 (
    .clk(clk), .rst(rst), .ctl(ctl1), .addr(maddr), .weight(w_q), .sample(s1_q),
    .den(ws_rd), .res(res1), .res_done(rdone1)
  );

  always_ff @(posedge clk) begin
    if (state == S_RD) ws_rd <= ws_mem[maddr];
    if (state == S_CLR) ws_mem[maddr] <= '0;
    else if (state == S_EXE && valid_q && cmd_q == CMD_CLEAR) ws_mem[maddr] <= '0;
    else if (state == S_EXE && valid_q && cmd_q == CMD_ADD)
      ws_mem[maddr] <= ws_sum[WS_W] ? {WS_W{1'b1}} : ws_sum[WS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      s0_q  <= sample_ch0;
      s1_q  <= sample_ch1;
      w_q   <= HANN_ROM[segment_offset];
      case (command)
        CMD_ADD: begin
          addr_q  <= pos[POS_W-1:0];
          valid_q <= !pos[16] && pos < total_samples;
        end
        CMD_READ: begin
          addr_q  <= segment_start;
          valid_q <= {1'b0, segment_start} < total_samples;
        end
        CMD_CLEAR: begin
          addr_q  <= segment_start;
          valid_q <= 1'b1;
        end
        default: begin
          addr_q  <= segment_start;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      total_samples <= 17'd65536;
      num_channels  <= 2'd2;
      done          <= 1'b0;
      covered       <= 1'b0;
      out_ch0       <= '0;
      out_ch1       <= '0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_TOTAL: total_samples <= wr_data;
          REG_NCH:   num_channels  <= wr_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + POS_W'(1);
          if (clr_addr == {POS_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: if (accept) state <= S_RD;
        S_RD: state <= S_EXE;
        S_EXE: begin
          if (cmd_q == CMD_READ) begin
            if (ctl0.div) state <= S_DIV;
            else begin
              state   <= S_IDLE;
              done    <= 1'b1;
              covered <= 1'b0;
              out_ch0 <= '0;
              out_ch1 <= '0;
            end
          end else state <= S_IDLE;
        end
        S_DIV: if (rdone0) begin
          state   <= S_IDLE;
          done    <= 1'b1;
          covered <= 1'b1;
          out_ch0 <= res0;
          out_ch1 <= ch1_on ? res1 : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_PROP(a_done_single, clk, rst, done |=> !done, "result strobe held two cycles")
  `CHK_PROP(a_accept_busy, clk, rst, accept |=> busy, "item taken but not busy")
  `CHK_PROP(a_uncov_zero, clk, rst, (done && !covered) |-> (out_ch0 == '0 && out_ch1 == '0),
            "uncovered read gave nonzero output")
  `CHK_PROP(a_lanes_sync, clk, rst, rdone0 == rdone1, "lane dividers out of step")

endmodule

@@ rtl/wola_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wola_lane
// One channel: accumulator memory with saturating read-modify-write, and a
// bit-serial rounding divider for the normalized read-out.
// ----------------------------------------------------------------------------
module wola_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  wola_pkg::lane_ctl_t                ctl,
  input  logic [wola_pkg::POS_W-1:0]         addr,
  input  logic [wola_pkg::W_W-1:0]           weight,
  input  logic signed [wola_pkg::SMP_W-1:0]  sample,
  input  logic [wola_pkg::WS_W-1:0]          den,
  output logic signed [wola_pkg::SMP_W-1:0]  res,
  output logic                               res_done
);
  import wola_pkg::*;

  logic signed [ACC_W-1:0] acc_mem [1 << POS_W];
  logic signed [ACC_W-1:0] acc_rd;
  logic signed [ACC_W-1:0] acc_wr;
  logic signed [31:0]      prod;
  logic signed [ACC_W:0]   sum;

  logic                    running;
  logic [4:0]              cnt;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        dsh;
  logic [QB-1:0]           q;
  logic                    sat;
  logic                    neg;
  logic signed [REM_W-1:0] acc_ext;
  logic [REM_W-1:0]        half;
  logic                    ge;
  logic [QB-1:0]           qf;
  logic                    big;

  assign prod = signed'({1'b0, weight}) * sample;
  assign sum  = (ACC_W+1)'(acc_rd) + (ACC_W+1)'(prod);

  always_comb begin
    if (sum > (ACC_W+1)'(signed'({1'b0, {(ACC_W-1){1'b1}}})))
      acc_wr = {1'b0, {(ACC_W-1){1'b1}}};
    else if (sum < (ACC_W+1)'(signed'({1'b1, {(ACC_W-1){1'b0}}})))
      acc_wr = {1'b1, {(ACC_W-1){1'b0}}};
    else
      acc_wr = sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) acc_rd <= acc_mem[addr];
    if (ctl.wr_clr) acc_mem[addr] <= '0;
    else if (ctl.wr_add) acc_mem[addr] <= acc_wr;
  end

  assign acc_ext = REM_W'(acc_rd);
  assign half    = REM_W'(den >> 1);
  assign ge      = rem >= dsh;
  assign qf      = {q[QB-2:0], ge};
  assign big     = sat || (neg ? (qf > QB'(32768)) : (qf > QB'(32767)));

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      res_done <= 1'b0;
      cnt      <= '0;
    end else begin
      res_done <= 1'b0;
      if (ctl.div) begin
        running <= 1'b1;
        cnt     <= 5'(QB - 1);
      end else if (running) begin
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          running  <= 1'b0;
          res_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div) begin
      rem <= acc_rd[ACC_W-1] ? (half - unsigned'(acc_ext)) : (unsigned'(acc_ext) + half);
      dsh <= REM_W'(den) << (QB - 1);
      q   <= '0;
      sat <= 1'b0;
      neg <= acc_rd[ACC_W-1];
    end else if (running) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      q   <= qf;
      if (cnt == 5'(QB - 1) && ge) sat <= 1'b1;
      if (cnt == '0) begin
        if (neg) res <= big ? 16'sh8000 : -signed'(qf[SMP_W-1:0]);
        else     res <= big ? 16'sh7FFF : signed'(qf[SMP_W-1:0]);
      end
    end
  end

endmodule
